// ===== design/dnm_pkg.sv =====
// ----------------------------------------------------------------------------
// dnm_pkg
// Shared widths, sigmoid breakpoints and stage types for the dense neuron.
// ----------------------------------------------------------------------------
package dnm_pkg;

  localparam int unsigned DATA_W    = 16;  // q4.12 operand width
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned OUT_W     = 15;
  localparam int unsigned ACC_W_DEF = 40;
  localparam int unsigned SIG_W     = 13;  // sigmoid value, 0..4096

  localparam logic [DATA_W:0] SIG_SAT_LIM = 17'd20480;  // 5.0
  localparam logic [DATA_W:0] SIG_MID_LIM = 17'd9728;   // 2.375
  localparam logic [DATA_W:0] SIG_LOW_LIM = 17'd4096;   // 1.0

  localparam logic [SIG_W-1:0] SIG_ONE     = 13'd4096;
  localparam logic [SIG_W-1:0] SIG_MID_OFS = 13'd3456;
  localparam logic [SIG_W-1:0] SIG_LOW_OFS = 13'd2560;
  localparam logic [SIG_W-1:0] SIG_ZRO_OFS = 13'd2048;

  // closing sum, floored to q4.12 and clamped to 16 bits
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] sum;
  } sum_t;

endpackage

// ===== design/dnm_ifs.sv =====
// ----------------------------------------------------------------------------
// dnm channel interfaces
// Input term channel, activation result channel and configuration channel.
// ----------------------------------------------------------------------------
interface dnm_in_if;
  import dnm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] weight;
  logic signed [DATA_W-1:0] act_in;
  logic signed [DATA_W-1:0] bias;
  logic                     first;
  logic                     last;
  modport source (output valid, weight, act_in, bias, first, last, input ready);
  modport sink (input valid, weight, act_in, bias, first, last, output ready);
endinterface

interface dnm_out_if;
  import dnm_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] act_out;
  modport source (output valid, act_out, input ready);
  modport sink (input valid, act_out, output ready);
endinterface

interface dnm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/dnm_mac.sv =====
// ----------------------------------------------------------------------------
// dnm_mac
// Input register, product register and saturating accumulator. A closing
// request hands the floored, clamped q4.12 sum to the activation stage.
// ----------------------------------------------------------------------------
module dnm_mac #(
  parameter int unsigned ACC_WIDTH = dnm_pkg::ACC_W_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dnm_in_if.sink        in_i,
  output dnm_pkg::sum_t sum_o,
  input  logic          sum_ready_i
);
  import dnm_pkg::*;

  localparam int unsigned SUM_W  = ACC_WIDTH + 1;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned Q_W    = SUM_W - FRAC_W;

  // input stage
  logic                     s1_vq;
  logic signed [DATA_W-1:0] w_q, x_q, b1_q;
  logic                     f1_q, l1_q;
  // product stage
  logic                     s2_vq;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] b2_q;
  logic                     f2_q, l2_q;
  // accumulator and closing sum
  logic [ACC_WIDTH-1:0]     acc_q, acc_d;
  logic                     sum_vq;
  logic signed [DATA_W-1:0] sum_q, sum_d;

  logic s3_free, s2_move, s2_free, s1_move, s1_free, in_acc;

  logic [ACC_WIDTH-1:0] base;
  logic [SUM_W-1:0]     total;
  logic [Q_W-1:0]       q_full;
  logic [Q_W-DATA_W:0]  q_top;

  assign s3_free = !sum_vq || sum_ready_i;
  assign s2_move = s2_vq && (!l2_q || s3_free);
  assign s2_free = !s2_vq || s2_move;
  assign s1_move = s1_vq && s2_free;
  assign s1_free = !s1_vq || s1_move;
  assign in_i.ready = s1_free;
  assign in_acc = in_i.valid && s1_free;

  always_comb begin
    if (f2_q) begin
      base = {{(ACC_WIDTH - DATA_W - FRAC_W){b2_q[DATA_W-1]}}, b2_q, {FRAC_W{1'b0}}};
    end else begin
      base = acc_q;
    end
    total = {base[ACC_WIDTH-1], base} +
            {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (total[SUM_W-1] != total[SUM_W-2]) begin
      acc_d = total[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_d = total[ACC_WIDTH-1:0];
    end
    // clamping the unsaturated sum matches clamping the saturated one
    q_full = total[SUM_W-1:FRAC_W];
    q_top  = q_full[Q_W-1:DATA_W-1];
    if ((&q_top) || !(|q_top)) begin
      sum_d = q_full[DATA_W-1:0];
    end else begin
      sum_d = q_full[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                            : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      s2_vq  <= 1'b0;
      sum_vq <= 1'b0;
      acc_q  <= '0;
    end else begin
      if (s1_free) begin
        s1_vq <= in_i.valid;
      end
      if (s2_free) begin
        s2_vq <= s1_vq;
      end
      if (s3_free) begin
        sum_vq <= s2_move && l2_q;
      end
      if (s2_move) begin
        acc_q <= l2_q ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q  <= in_i.weight;
      x_q  <= in_i.act_in;
      b1_q <= in_i.bias;
      f1_q <= in_i.first;
      l1_q <= in_i.last;
    end
    if (s1_move) begin
      prod_q <= w_q * x_q;
      b2_q   <= b1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
    end
    if (s2_move && l2_q && s3_free) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o.valid = sum_vq;
  assign sum_o.sum   = sum_q;

endmodule

// ===== design/dnm_act.sv =====
// ----------------------------------------------------------------------------
// dnm_act
// ReLU or piecewise-linear sigmoid on the closing sum, into the result
// register.
// ----------------------------------------------------------------------------
module dnm_act (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dnm_pkg::sum_t sum_i,
  output logic          sum_ready_o,
  input  logic          sigmoid_i,
  dnm_out_if.source     out_o
);
  import dnm_pkg::*;

  logic             out_vq;
  logic [OUT_W-1:0] out_q, out_d;
  logic             out_free;
  logic [DATA_W:0]  mag;
  logic [SIG_W-1:0] sig_pos, sig_val;
  logic             neg;

  assign out_free    = !out_vq || out_o.ready;
  assign sum_ready_o = out_free;
  assign neg         = sum_i.sum[DATA_W-1];

  always_comb begin
    if (neg) begin
      mag = {(DATA_W+1){1'b0}} - {sum_i.sum[DATA_W-1], sum_i.sum};
    end else begin
      mag = {1'b0, sum_i.sum};
    end
    priority if (mag >= SIG_SAT_LIM) begin
      sig_pos = SIG_ONE;
    end else if (mag >= SIG_MID_LIM) begin
      sig_pos = SIG_W'(mag >> 5) + SIG_MID_OFS;
    end else if (mag >= SIG_LOW_LIM) begin
      sig_pos = SIG_W'(mag >> 3) + SIG_LOW_OFS;
    end else begin
      sig_pos = SIG_W'(mag >> 2) + SIG_ZRO_OFS;
    end
    sig_val = neg ? (SIG_ONE - sig_pos) : sig_pos;
    if (sigmoid_i) begin
      out_d = OUT_W'(sig_val);
    end else begin
      out_d = neg ? '0 : sum_i.sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_free) begin
      out_vq <= sum_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && sum_i.valid) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_vq;
  assign out_o.act_out = out_q;

endmodule

// ===== design/dense_neuron_mac_activation.sv =====
// ----------------------------------------------------------------------------
// dense_neuron_mac_activation
// One fully connected neuron: q4.12 multiply-accumulate with saturation,
// then ReLU or piecewise-linear sigmoid on the closing term.
//
//   channel  dir  payload                               handshake
//   in_i     in   weight, act_in, bias, first, last     valid/ready
//   out_o    out  act_out (15 bit)                      valid/ready
//   cfg_i    in   data (output_layer bit)               valid/ready
//
// one request per cycle unless out_o stalls; the accumulator add loop sets it
// a closing request passes the input, product, sum and result registers in turn
// reset clears the accumulator, output_layer and all stage valids
// each stage holds only while the stage after it is full and stalled
// ----------------------------------------------------------------------------
module dense_neuron_mac_activation #(
  parameter int unsigned ACC_WIDTH = dnm_pkg::ACC_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dnm_in_if.sink    in_i,
  dnm_out_if.source out_o,
  dnm_cfg_if.sink   cfg_i
);
  import dnm_pkg::*;

  logic output_layer_q;
  sum_t sum_s;
  logic sum_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_layer_q <= 1'b0;
    end else if (cfg_i.valid) begin
      output_layer_q <= cfg_i.data;
    end
  end

  dnm_mac #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .sum_o      (sum_s),
    .sum_ready_i(sum_ready)
  );

  dnm_act u_act (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sum_i      (sum_s),
    .sum_ready_o(sum_ready),
    .sigmoid_i  (output_layer_q),
    .out_o      (out_o)
  );

  a_sig_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && output_layer_q |-> out_o.act_out <= OUT_W'(SIG_ONE))
    else $error("sigmoid result above one");

  a_sum_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_s.valid && !sum_ready |=> sum_s.valid && $stable(sum_s.sum))
    else $error("closing sum lost while stalled");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(sum_s.valid))
    else $error("result without closing sum");

endmodule
